// ===== rtl/core/gqce_pkg.sv =====
// Package for the glyph quad clip/emit block: register indexes, word types,
// and the bundle passed from the front part to the back part.
// Used by every module in rtl/core but gqce_divider.
package gqce_pkg;

	localparam int RegIdxW = 3;
	localparam int CfgDataW = 32;

	typedef enum logic [RegIdxW-1:0] {
		REG_FLAGS      = 3'd0,
		REG_CLIP_X_MIN = 3'd1,
		REG_CLIP_Y_MIN = 3'd2,
		REG_CLIP_X_MAX = 3'd3,
		REG_CLIP_Y_MAX = 3'd4,
		REG_BASELINE   = 3'd5,
		REG_U_BIAS     = 3'd6,
		REG_COLOR      = 3'd7
	} reg_idx_t;

	localparam logic [20:0] CodeAdvance = 21'd1;

	// Input data word: char_code, arg_x, arg_y, glyph_width, glyph_height,
	// tex_u_start, tex_v_start, tex_u_size, tex_v_size, advance, kerning_offset.
	// The func field travels beside it as tuser.
	localparam int InDataW = 21 + 24 + 24 + 10 + 10 + 16 * 4 + 16 + 16;
	localparam int InBytesW = ((InDataW + 7) / 8) * 8;
	// Output word: vertex_x, vertex_y, tex_u, tex_v, color.
	localparam int OutW = 16 + 16 + 18 + 17 + 32;
	localparam int OutBytesW = ((OutW + 7) / 8) * 8;

	// Geometry is carried at 27 bits signed; all sums fit.
	typedef logic signed [26:0] coord_t;

	// Classified glyph from the front part.
	typedef struct packed {
		coord_t      xa;
		coord_t      xb;
		coord_t      yc;
		coord_t      yd;
		logic [9:0]  gw;
		logic [9:0]  gh;
		logic [15:0] ua;
		logic [15:0] us;
		logic [15:0] vc;
		logic [15:0] vs;
	} glyph_t;

	// Configuration seen by both parts.
	typedef struct packed {
		logic [2:0]         flags;
		logic signed [23:0] clip_x_min;
		logic signed [23:0] clip_y_min;
		logic signed [23:0] clip_x_max;
		logic signed [23:0] clip_y_max;
		logic signed [15:0] baseline;
		logic [1:0]         u_bias;
		logic [31:0]        color;
	} cfg_t;

endpackage

// ===== rtl/core/glyph_quad_clip_emit.sv =====
// Top level of the glyph quad clip/emit block: configuration registers,
// front part, queue and back part. Depends on gqce_pkg and all rtl/core modules.
//
// channel   direction  contents
// s_axis    in         one glyph or pen word per accepted word, tuser is func
// m_axis    out        one vertex per word, tlast on the sixth
// cfg       in         register write, index and data, no wait
//
// A pen word or a word rejected by the front part never reaches the back part.
// In the back part a drawn glyph is loaded, its edges are checked in turn and,
// unless the clipped rectangle is empty, six vertices are emitted; each cut edge
// with a non-zero glyph extent adds a multiply and a one-bit-per-cycle divide.
// Reset clears the pen, the queue and registers to their reset values.
// A two-entry queue lets the front part keep accepting while the back stalls.
module glyph_quad_clip_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gqce_pkg::RegIdxW-1:0] cfg_idx,
	input  logic [gqce_pkg::CfgDataW-1:0] cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// char_code, arg_x, arg_y, glyph_width, glyph_height, tex_u_start,
	// tex_v_start, tex_u_size, tex_v_size, advance, kerning_offset (low first)
	input  logic [gqce_pkg::InBytesW-1:0] s_axis_tdata,
	// func
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// vertex_x, vertex_y, tex_u, tex_v, color (low first)
	output logic [gqce_pkg::OutBytesW-1:0] m_axis_tdata,
	output logic                        m_axis_tlast
);
	import gqce_pkg::*;

	cfg_t   cfg_q;
	logic   fq_valid, fq_ready, qb_valid, qb_ready;
	glyph_t fq_glyph, qb_glyph;
	logic [OutW-1:0] odata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{flags: 3'd2, clip_x_min: '0, clip_y_min: '0, clip_x_max: '0,
				clip_y_max: '0, baseline: '0, u_bias: '0, color: 32'hFFFF_FFFF};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_FLAGS:      cfg_q.flags <= cfg_wdata[2:0];
				REG_CLIP_X_MIN: cfg_q.clip_x_min <= cfg_wdata[23:0];
				REG_CLIP_Y_MIN: cfg_q.clip_y_min <= cfg_wdata[23:0];
				REG_CLIP_X_MAX: cfg_q.clip_x_max <= cfg_wdata[23:0];
				REG_CLIP_Y_MAX: cfg_q.clip_y_max <= cfg_wdata[23:0];
				REG_BASELINE:   cfg_q.baseline <= cfg_wdata[15:0];
				REG_U_BIAS:     cfg_q.u_bias <= cfg_wdata[1:0];
				REG_COLOR:      cfg_q.color <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gqce_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_func(s_axis_tuser), .in_data(s_axis_tdata[InDataW-1:0]),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_glyph(fq_glyph)
	);

	gqce_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_glyph),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_glyph)
	);

	gqce_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(qb_valid), .q_ready(qb_ready), .q_glyph(qb_glyph),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(odata), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {{(OutBytesW - OutW){1'b0}}, odata};
endmodule

// ===== rtl/core/gqce_front.sv =====
// Front part: accepts input words, keeps the pen, builds the rectangle and
// drops advance words and rejected or disabled glyphs. Depends on gqce_pkg.
module gqce_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gqce_pkg::cfg_t          cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_func,
	input  logic [gqce_pkg::InDataW-1:0] in_data,
	output logic                    q_valid,
	input  logic                    q_ready,
	output gqce_pkg::glyph_t        q_glyph
);
	import gqce_pkg::*;

	logic               func;
	logic [20:0]        code;
	logic signed [23:0] ax, ay;
	logic [9:0]         gw, gh;
	logic [15:0]        us0, vs0, usz, vsz, adv;
	logic signed [15:0] kin;
	logic signed [23:0] pen_x_q, pen_y_q;
	coord_t             kern, xa, xb, yc, yd;
	logic               clip, drop, live, fire;
	glyph_t             g;

	assign func = in_func;
	assign {kin, adv, vsz, usz, vs0, us0, gh, gw, ay, ax, code} = in_data;

	// Rectangle corners and reject test.
	always_comb begin
		kern = cfg.flags[1] ? coord_t'(kin) : '0;
		xa = coord_t'(pen_x_q) + coord_t'(ax) + kern;
		xb = xa + coord_t'({gw, 8'd0});
		yc = coord_t'(pen_y_q) + coord_t'(ay) + coord_t'(cfg.baseline);
		yd = yc - coord_t'({gh, 8'd0});
		clip = cfg.flags[0];
		drop = clip && (xb < coord_t'(cfg.clip_x_min) || xa > coord_t'(cfg.clip_x_max)
			|| yc < coord_t'(cfg.clip_y_min) || yd > coord_t'(cfg.clip_y_max));
		live = !func && code != CodeAdvance && !drop && cfg.flags[2];
		g = '{xa: xa, xb: xb, yc: yc, yd: yd, gw: gw, gh: gh,
			ua: us0, us: usz, vc: vs0, vs: vsz};
	end

	// A word that is not queued never waits on the queue.
	assign in_ready = !live || q_ready;
	assign fire = in_valid && in_ready;
	assign q_valid = in_valid && live;
	assign q_glyph = g;

	// Pen update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (fire) begin
			if (func) begin
				pen_x_q <= ax;
				pen_y_q <= ay;
			end else begin
				pen_x_q <= pen_x_q + 24'(adv) + kern[23:0];
			end
		end
	end
endmodule

// ===== rtl/core/gqce_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on gqce_pkg for the glyph bundle.
module gqce_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  gqce_pkg::glyph_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output gqce_pkg::glyph_t rd_data
);
	import gqce_pkg::*;

	glyph_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !rd) else $error("pop from empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count mismatch");
endmodule

// ===== rtl/core/gqce_divider.sv =====
// Restoring divider: 26-bit dividend over 18-bit divisor, one bit a cycle.
// Self-contained; no package use beyond none.
module gqce_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [25:0] dividend,
	input  logic [17:0] divisor,
	output logic        busy,
	output logic [25:0] quotient
);
	logic [25:0] quo_q;
	logic [18:0] rem_q;
	logic [17:0] dvs_q;
	logic [4:0]  cnt_q;
	logic [18:0] shifted, diff;

	assign shifted = {rem_q[17:0], quo_q[25]};
	assign diff = shifted - {1'b0, dvs_q};
	assign busy = cnt_q != 5'd0;
	assign quotient = quo_q;

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd26;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!diff[18]) begin
				rem_q <= diff;
				quo_q <= {quo_q[24:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[24:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/gqce_back.sv =====
// Back part: clips a queued glyph edge by edge with a shared multiplier and
// divider, then, unless the result is empty, emits six vertices through an output register.
// Depends on gqce_pkg and gqce_divider.
module gqce_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gqce_pkg::cfg_t              cfg,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  gqce_pkg::glyph_t            q_glyph,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gqce_pkg::OutW-1:0]   out_data,
	output logic                        out_last
);
	import gqce_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EDGE, S_MUL, S_DIV, S_EMIT} state_t;

	state_t      st_q;
	glyph_t      g_q;
	logic [1:0]  edge_q;
	logic [2:0]  k_q;
	logic signed [17:0] ua_q, ub_q, vc_q, vd_q;
	logic [25:0] prod_q;
	logic [17:0] ext_q;
	logic        div_start, div_busy;
	logic [25:0] quo;
	logic [OutW-1:0] data_q;
	logic        valid_q, last_q;

	// Per-edge cut amount, extent and size selection.
	logic        need;
	coord_t      cut;
	logic [9:0]  ext;
	logic [15:0] sz;
	logic [33:0] prod;
	logic signed [17:0] sh;

	always_comb begin
		need = 1'b0;
		cut = '0;
		ext = g_q.gw;
		sz = g_q.us;
		case (edge_q)
			2'd0: begin
				need = g_q.xa < coord_t'(cfg.clip_x_min);
				cut = coord_t'(cfg.clip_x_min) - g_q.xa;
			end
			2'd1: begin
				need = g_q.xb > coord_t'(cfg.clip_x_max);
				cut = g_q.xb - coord_t'(cfg.clip_x_max);
			end
			2'd2: begin
				need = g_q.yc > coord_t'(cfg.clip_y_max);
				cut = g_q.yc - coord_t'(cfg.clip_y_max);
				ext = g_q.gh;
				sz = g_q.vs;
			end
			default: begin
				need = g_q.yd < coord_t'(cfg.clip_y_min);
				cut = coord_t'(cfg.clip_y_min) - g_q.yd;
				ext = g_q.gh;
				sz = g_q.vs;
			end
		endcase
		need = need && cfg.flags[0];
		// Cut never exceeds the extent here, so 18 bits hold it.
		prod = sz * cut[17:0];
		// The quotient never exceeds the size, so 16 bits hold it.
		sh = 18'(quo[15:0]);
	end

	assign div_start = st_q == S_MUL;
	gqce_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(ext_q), .busy(div_busy), .quotient(quo)
	);

	// Vertex fields for the current corner.
	logic        right, low;
	logic signed [19:0] u;
	logic signed [17:0] v;
	logic signed [17:0] px, py;
	logic [17:0] uo;
	logic [16:0] vo;
	logic [15:0] vx, vy;
	logic        emit_ok;

	function automatic logic [15:0] to_pix(input coord_t c);
		coord_t q;
		begin
			q = (c < 0) ? -((-c) >>> 8) : (c >>> 8);
			if (q > 27'sd32767) to_pix = 16'h7FFF;
			else if (q < -27'sd32768) to_pix = 16'h8000;
			else to_pix = q[15:0];
		end
	endfunction

	always_comb begin
		right = k_q == 3'd1 || k_q == 3'd2 || k_q == 3'd4;
		low = k_q == 3'd2 || k_q == 3'd4 || k_q == 3'd5;
		u = 20'(right ? ub_q : ua_q) + 20'({cfg.u_bias, 16'd0});
		v = low ? vd_q : vc_q;
		uo = (u < 0) ? '0 : (u > 20'sd262143) ? 18'h3FFFF : u[17:0];
		vo = (v < 0) ? '0 : v[16:0];
		vx = to_pix(right ? g_q.xb : g_q.xa);
		vy = to_pix(low ? g_q.yd : g_q.yc);
	end

	// A vertex is loaded into the output register this cycle.
	assign emit_ok = st_q == S_EMIT && g_q.xb > g_q.xa && g_q.yd < g_q.yc
		&& (!valid_q || out_ready);

	assign q_ready = st_q == S_IDLE;
	assign out_valid = valid_q;
	assign out_data = data_q;
	assign out_last = last_q;

	// Sequencer: clip the edges in turn, check emptiness, emit six vertices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			valid_q <= 1'b0;
			edge_q <= '0;
			k_q <= '0;
		end else begin
			if (valid_q && out_ready && !emit_ok) valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						g_q <= q_glyph;
						ua_q <= 18'(q_glyph.ua);
						ub_q <= 18'(q_glyph.ua) + 18'(q_glyph.us);
						vc_q <= 18'(q_glyph.vc);
						vd_q <= 18'(q_glyph.vc) + 18'(q_glyph.vs);
						edge_q <= '0;
						st_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (need) begin
						unique case (edge_q)
							2'd0: g_q.xa <= coord_t'(cfg.clip_x_min);
							2'd1: g_q.xb <= coord_t'(cfg.clip_x_max);
							2'd2: g_q.yc <= coord_t'(cfg.clip_y_max);
							default: g_q.yd <= coord_t'(cfg.clip_y_min);
						endcase
					end
					if (need && ext != 10'd0) begin
						// Dropping the low 8 bits first leaves the floor unchanged.
						prod_q <= prod[33:8];
						ext_q <= 18'(ext);
						st_q <= S_MUL;
					end else if (edge_q == 2'd3) begin
						k_q <= '0;
						st_q <= S_EMIT;
					end else begin
						edge_q <= edge_q + 2'd1;
					end
				end
				S_MUL: st_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						unique case (edge_q)
							2'd0: ua_q <= ua_q + sh;
							2'd1: ub_q <= ub_q - sh;
							2'd2: vc_q <= vc_q + sh;
							default: vd_q <= vd_q - sh;
						endcase
						if (edge_q == 2'd3) begin
							k_q <= '0;
							st_q <= S_EMIT;
						end else begin
							edge_q <= edge_q + 2'd1;
							st_q <= S_EDGE;
						end
					end
				end
				S_EMIT: begin
					if (!(g_q.xb > g_q.xa && g_q.yd < g_q.yc)) begin
						st_q <= S_IDLE;
					end else if (emit_ok) begin
						valid_q <= 1'b1;
						data_q <= {cfg.color, vo, uo, vy, vx};
						last_q <= k_q == 3'd5;
						if (k_q == 3'd5) st_q <= S_IDLE;
						else k_q <= k_q + 3'd1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> st_q == S_IDLE) else $error("queue read outside idle");
	a_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> st_q == S_EMIT) else $error("glyph left before last vertex");
endmodule

// ===== tb/gqce_checker.sv =====
// Checker for the glyph quad clip/emit block: tracks the configuration and the
// pen, predicts the vertex words of each accepted glyph word and compares them.
// Depends on gqce_pkg.
module gqce_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gqce_pkg::RegIdxW-1:0]      cfg_idx,
	input  logic [gqce_pkg::CfgDataW-1:0]     cfg_wdata,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [gqce_pkg::InBytesW-1:0]     s_axis_tdata,
	input  logic                              s_axis_tuser,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [gqce_pkg::OutBytesW-1:0]    m_axis_tdata,
	input  logic                              m_axis_tlast,
	output int                                fail_count,
	output int                                pending
);
	import gqce_pkg::*;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [17:0]        u;
		logic [16:0]        v;
		logic [31:0]        color;
		logic               last;
	} vertex_t;

	vertex_t vertex_q[$];

	logic [2:0] flags;
	longint cxmin, cymin, cxmax, cymax, base;
	logic [1:0] ubias;
	logic [31:0] dcolor;
	longint pen_x, pen_y;

	assign pending = vertex_q.size();

	function automatic longint sx(longint v, int w);
		longint m;
		m = longint'(1) << (w - 1);
		v = v & ((longint'(1) << w) - 1);
		return (v ^ m) - m;
	endfunction

	function automatic logic [15:0] pixel_of(longint v);
		longint q;
		q = v / 256;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic longint uv_shift(longint size, longint cut, longint ext);
		if (ext <= 0) return 0;
		return (size * cut) / (ext * 256);
	endfunction

	// Place one glyph word: queue its vertices and move the pen.
	task automatic place_glyph(logic func, logic [InBytesW-1:0] d);
		longint ax, ay, gw, gh, us, vs, adv, kern, xa, xb, yc, yd, ua, ub, vc, vd;
		longint uu, vv;
		logic [20:0] code;
		bit clip, drop, right, low;
		int c;
		vertex_t vt;
		int corner[6];
		corner = '{0, 1, 2, 0, 2, 3};
		code = d[20:0];
		ax = sx(d[44:21], 24);
		ay = sx(d[68:45], 24);
		gw = d[78:69];
		gh = d[88:79];
		ua = d[104:89];
		vc = d[120:105];
		us = d[136:121];
		vs = d[152:137];
		adv = d[168:153];
		kern = flags[1] ? sx(d[184:169], 16) : 0;
		if (func) begin
			pen_x = ax;
			pen_y = ay;
			return;
		end
		if (code != CodeAdvance) begin
			xa = pen_x + ax + kern;
			xb = xa + gw * 256;
			yc = pen_y + ay + base;
			yd = yc - gh * 256;
			ub = ua + us;
			vd = vc + vs;
			clip = flags[0];
			drop = clip && (xb < cxmin || xa > cxmax || yc < cymin || yd > cymax);
			if (!drop) begin
				if (clip) begin
					if (xa < cxmin) begin ua += uv_shift(us, cxmin - xa, gw); xa = cxmin; end
					if (xb > cxmax) begin ub -= uv_shift(us, xb - cxmax, gw); xb = cxmax; end
					if (yc > cymax) begin vc += uv_shift(vs, yc - cymax, gh); yc = cymax; end
					if (yd < cymin) begin vd -= uv_shift(vs, cymin - yd, gh); yd = cymin; end
				end
				if (xb > xa && yd < yc && flags[2]) begin
					for (int k = 0; k < 6; k++) begin
						c = corner[k];
						right = (c == 1 || c == 2);
						low = (c == 2 || c == 3);
						uu = (right ? ub : ua) + longint'(ubias) * 65536;
						vv = low ? vd : vc;
						if (uu > 262143) uu = 262143;
						if (uu < 0) uu = 0;
						if (vv < 0) vv = 0;
						vt.vx = pixel_of(right ? xb : xa);
						vt.vy = pixel_of(low ? yd : yc);
						vt.u = uu[17:0];
						vt.v = vv[16:0];
						vt.color = dcolor;
						vt.last = (k == 5);
						vertex_q = {vertex_q, vt};
					end
				end
			end
		end
		pen_x = sx(pen_x + adv + kern, 24);
	endtask

	// Compare one vertex word against the oldest prediction.
	task automatic check_vertex();
		vertex_t e;
		if (vertex_q.size() == 0) begin
			$error("vertex word with nothing expected");
			fail_count++;
			return;
		end
		e = vertex_q.pop_front();
		if (m_axis_tdata[15:0] !== e.vx) begin
			$error("vertex_x expected %0d actual %0d", e.vx, $signed(m_axis_tdata[15:0]));
			fail_count++;
		end
		if (m_axis_tdata[31:16] !== e.vy) begin
			$error("vertex_y expected %0d actual %0d", e.vy, $signed(m_axis_tdata[31:16]));
			fail_count++;
		end
		if (m_axis_tdata[49:32] !== e.u) begin
			$error("tex_u expected %0h actual %0h", e.u, m_axis_tdata[49:32]);
			fail_count++;
		end
		if (m_axis_tdata[66:50] !== e.v) begin
			$error("tex_v expected %0h actual %0h", e.v, m_axis_tdata[66:50]);
			fail_count++;
		end
		if (m_axis_tdata[98:67] !== e.color) begin
			$error("color expected %0h actual %0h", e.color, m_axis_tdata[98:67]);
			fail_count++;
		end
		if (m_axis_tlast !== e.last) begin
			$error("last expected %0b actual %0b", e.last, m_axis_tlast);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	// Track registers and channels at each clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags = 3'd2;
			cxmin = 0; cymin = 0; cxmax = 0; cymax = 0; base = 0;
			ubias = 0;
			dcolor = 32'hFFFF_FFFF;
			pen_x = 0; pen_y = 0;
			vertex_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) check_vertex();
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_FLAGS: flags = cfg_wdata[2:0];
					REG_CLIP_X_MIN: cxmin = sx(cfg_wdata, 24);
					REG_CLIP_Y_MIN: cymin = sx(cfg_wdata, 24);
					REG_CLIP_X_MAX: cxmax = sx(cfg_wdata, 24);
					REG_CLIP_Y_MAX: cymax = sx(cfg_wdata, 24);
					REG_BASELINE: base = sx(cfg_wdata, 16);
					REG_U_BIAS: ubias = cfg_wdata[1:0];
					REG_COLOR: dcolor = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) place_glyph(s_axis_tuser, s_axis_tdata);
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the glyph quad clip/emit block: clock, reset, register
// writes, glyph and pen words with random idling, and the verdict.
// Depends on gqce_pkg, gqce_checker and the block itself.
module tb_top;
	import gqce_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [RegIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [InBytesW-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OutBytesW-1:0] m_axis_tdata;
	logic m_axis_tlast;
	int fail_count;
	int pending;
	int cycle_count;
	bit quiet;

	glyph_quad_clip_emit DUT (.*);

	gqce_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle limit: the words sent plus idling, many times over.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, none late in the run.
	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 15);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1;
			repeat (n) @(posedge clk);
		end
	end

	// Packs func in bit 0 and the data word above it.
	function automatic logic [InBytesW:0] pack_word(logic func, logic [20:0] code,
			logic [23:0] ax, logic [23:0] ay, logic [9:0] gw, logic [9:0] gh,
			logic [15:0] us0, logic [15:0] vs0, logic [15:0] usz, logic [15:0] vsz,
			logic [15:0] adv, logic [15:0] kern);
		logic [InBytesW:0] w;
		w = '0;
		w[185:0] = {kern, adv, vsz, usz, vs0, us0, gh, gw, ay, ax, code, func};
		return w;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Send one word, with an optional idle burst first.
	task automatic send(logic [InBytesW:0] w);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= w[0];
		s_axis_tdata <= w[InBytesW:1];
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [23:0] rnd_pos();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 24'(int'($urandom_range(0, 20000)) - 10000);
			default: return 24'(int'($urandom_range(0, 4000)) - 1000);
		endcase
	endfunction

	task automatic send_random();
		logic [9:0] gw, gh;
		logic [20:0] code;
		if ($urandom_range(0, 9) == 0) begin
			send(pack_word(1, $urandom, rnd_pos(), rnd_pos(), $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
			return;
		end
		code = ($urandom_range(0, 9) == 0) ? CodeAdvance : 21'($urandom);
		gw = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
		gh = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
		send(pack_word(0, code, rnd_pos(), rnd_pos(), gw, gh, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom));
	endtask

	// Random window and settings; the clip window is sometimes inverted.
	task automatic random_config();
		int lo, hi;
		lo = int'($urandom_range(0, 3000)) - 1500;
		hi = lo + int'($urandom_range(0, 4000)) - 300;
		write_reg(REG_FLAGS, $urandom_range(0, 7) | 32'd4);
		write_reg(REG_CLIP_X_MIN, lo);
		write_reg(REG_CLIP_X_MAX, hi);
		lo = int'($urandom_range(0, 3000)) - 1500;
		hi = lo + int'($urandom_range(0, 4000)) - 300;
		write_reg(REG_CLIP_Y_MIN, lo);
		write_reg(REG_CLIP_Y_MAX, hi);
		write_reg(REG_BASELINE, $urandom);
		write_reg(REG_U_BIAS, $urandom_range(0, 3));
		write_reg(REG_COLOR, $urandom);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		quiet = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset settings draw nothing; then emit with no clipping.
		send(pack_word(0, 21'h41, 0, 24'h000A00, 10'd4, 10'd5, 16'h1000, 16'h2000,
			16'h0800, 16'h0800, 16'h0600, 16'h0100));
		go_idle();
		write_reg(REG_FLAGS, 32'd6);
		write_reg(REG_U_BIAS, 32'd3);
		write_reg(REG_COLOR, 32'h1234_5678);
		send(pack_word(1, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0, 0, 0, 0));
		// Saturating positions and u, extremes of sizes.
		send(pack_word(0, 21'h1FFFFF, 24'h7FFFFF, 24'h7FFFFF, 10'h3FF, 10'h3FF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF));
		send(pack_word(0, CodeAdvance, 0, 0, 10'd3, 10'd3, 0, 0, 0, 0, 16'hFFFF, 16'h8000));
		send(pack_word(1, 0, 24'hFFF000, 24'hFFF000, 0, 0, 0, 0, 0, 0, 0, 0));
		send(pack_word(0, 21'h20, 24'h800000, 24'h800000, 10'd0, 10'd7, 0, 0, 0, 0, 0, 0));
		send(pack_word(0, 21'h21, 24'hFFFF80, 24'h000080, 10'd1, 10'd1, 0, 0, 16'h100,
			16'h100, 16'h300, 0));
		go_idle();
		// Clipping: window of 0..10 px with glyphs cut on every edge and rejected.
		write_reg(REG_FLAGS, 32'd7);
		write_reg(REG_CLIP_X_MIN, 0);
		write_reg(REG_CLIP_Y_MIN, 0);
		write_reg(REG_CLIP_X_MAX, 32'h0A00);
		write_reg(REG_CLIP_Y_MAX, 32'h0A00);
		write_reg(REG_BASELINE, 32'hFF00);
		send(pack_word(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(pack_word(0, 21'h30, 24'hFFFE80, 24'h000C80, 10'd14, 10'd14, 16'h0100, 16'h0200,
			16'h8000, 16'h8000, 0, 16'hFF80));
		send(pack_word(0, 21'h31, 24'h001400, 24'h000200, 10'd2, 10'd2, 0, 0, 16'h10,
			16'h10, 0, 0));
		send(pack_word(0, 21'h32, 24'hFFEC00, 24'h000500, 10'd2, 10'd2, 0, 0, 16'h10,
			16'h10, 0, 0));
		send(pack_word(0, 21'h33, 24'h000100, 24'h000500, 10'd0, 10'd3, 0, 0, 16'hFFFF,
			16'hFFFF, 0, 0));
		go_idle();
		write_reg(REG_CLIP_X_MIN, 32'h00800000);
		write_reg(REG_CLIP_X_MAX, 32'h007FFFFF);
		send(pack_word(0, 21'h34, 0, 24'h000500, 10'd2, 10'd2, 0, 0, 0, 0, 0, 0));
		go_idle();
		write_reg(REG_CLIP_X_MIN, 32'h00FFFF00);
		write_reg(REG_CLIP_Y_MIN, 32'h00800000);
		write_reg(REG_CLIP_X_MAX, 32'h00000100);
		write_reg(REG_CLIP_Y_MAX, 32'h007FFFFF);
		write_reg(REG_BASELINE, 32'h7FFF);
		send(pack_word(0, 21'h35, 24'hFFFC00, 24'h000000, 10'd8, 10'd8, 16'h4000, 16'h4000,
			16'h4000, 16'h4000, 0, 0));
		go_idle();

		// Random phases, with full idle (sender waits for all results) between.
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			for (int i = 0; i < 30; i++) send_random();
			go_idle();
		end
		quiet = 1;
		random_config();
		for (int i = 0; i < 30; i++) send_random();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
